>>> rtl/windowed_fault_health_monitor_core_macros.svh
`ifndef WINDOWED_FAULT_HEALTH_MONITOR_CORE_MACROS_SVH
`define WINDOWED_FAULT_HEALTH_MONITOR_CORE_MACROS_SVH

// same-cycle check: cons must hold whenever ante holds
`define WHFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle check: cons must hold in the cycle after ante
`define WHFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/whfm_pkg.sv
package whfm_pkg;

   localparam int unsigned OUT_W     = 11;
   localparam int unsigned THR_W     = 11;
   localparam int unsigned TOTAL_W   = 32;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned N_KINDS   = 4;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      HEALTH_GOOD,
      HEALTH_WARNING,
      HEALTH_CRITICAL,
      HEALTH_EMERGENCY
   } health_type;

   typedef enum logic {
      FUNC_RECORD,
      FUNC_CLEAR
   } func_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMERGENCY = 2'd2;

   localparam logic [THR_W-1:0] WARNING_RESET   = 11'd1;
   localparam logic [THR_W-1:0] CRITICAL_RESET  = 11'd5;
   localparam logic [THR_W-1:0] EMERGENCY_RESET = 11'd10;

   localparam logic [KIND_W-1:0] KIND_LASER     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VOLTAGE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EM        = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ROWHAMMER = 3'd4;

   // counted kinds, slot k holds the code of count k
   localparam logic [N_KINDS-1:0][KIND_W-1:0] KIND_CODES =
      {KIND_ROWHAMMER, KIND_EM, KIND_VOLTAGE, KIND_LASER};

   typedef struct packed {
      logic              failed;
      logic [KIND_W-1:0] kind;
   } entry_type;

   // per-item control passed from the ring access stage to the count stage
   typedef struct packed {
      logic              clear;
      logic              failed;
      logic [KIND_W-1:0] kind;
      logic              win_leave;
      logic              evict;
   } step_type;

   typedef struct packed {
      logic [THR_W-1:0] warning_above;
      logic [THR_W-1:0] critical_above;
      logic [THR_W-1:0] emergency_above;
   } thresh_type;

endpackage

>>> rtl/whfm_ring.sv
module whfm_ring #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic                wr_en,
   input  logic [AW-1:0]       slot_addr,
   input  logic [AW-1:0]       win_addr,
   input  whfm_pkg::entry_type wr_data,
   output whfm_pkg::entry_type slot_data,
   output whfm_pkg::entry_type win_data
);

   whfm_pkg::entry_type ring_ff [DEPTH];
   whfm_pkg::entry_type slot_rd_ff;
   whfm_pkg::entry_type win_rd_ff;

   // read-first: a read of the slot being written returns the old entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[slot_addr] <= wr_data;
      end
      if (rd_en) begin
         slot_rd_ff <= ring_ff[slot_addr];
         win_rd_ff  <= ring_ff[win_addr];
      end
   end

   assign slot_data = slot_rd_ff;
   assign win_data  = win_rd_ff;

endmodule

>>> rtl/whfm_tally.sv
`include "windowed_fault_health_monitor_core_macros.svh"

module whfm_tally #(
   parameter int unsigned CW      = 11,
   parameter int unsigned WIN_LEN = 50
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  whfm_pkg::step_type                   step,
   input  logic [CW-1:0]                        fill,
   input  whfm_pkg::entry_type                  slot_entry,
   input  whfm_pkg::entry_type                  win_entry,
   input  whfm_pkg::thresh_type                 thresh,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_health,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_held_samples,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_recent_failures,
   output logic [whfm_pkg::TOTAL_W-1:0]         rsp_failure_total,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_laser_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_voltage_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_em_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_rowhammer_in_history
);

   localparam int unsigned CMPW = (CW > whfm_pkg::THR_W) ? CW : whfm_pkg::THR_W;

   logic [CW-1:0]                 win_cnt_ff;
   logic [CW-1:0]                 win_cnt_in;
   logic [CW-1:0]                 kind_cnt_ff [whfm_pkg::N_KINDS];
   logic [CW-1:0]                 kind_cnt_in [whfm_pkg::N_KINDS];
   logic [whfm_pkg::TOTAL_W-1:0]  total_ff;
   logic [whfm_pkg::TOTAL_W-1:0]  total_in;
   whfm_pkg::health_type          health_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   whfm_pkg::health_type          health_ff;
   logic [whfm_pkg::OUT_W-1:0]    held_ff;
   logic [whfm_pkg::OUT_W-1:0]    recent_ff;
   logic [whfm_pkg::TOTAL_W-1:0]  total_out_ff;
   logic [whfm_pkg::OUT_W-1:0]    kind_out_ff [whfm_pkg::N_KINDS];

   always_comb begin
      logic          win_dec;
      logic          kind_inc;
      logic          kind_dec;
      logic [CMPW-1:0] win_cmp;

      win_dec    = step.win_leave && win_entry.failed && (win_cnt_ff != '0);
      win_cnt_in = win_cnt_ff - CW'(win_dec) + CW'(step.failed);

      for (int k = 0; k < whfm_pkg::N_KINDS; k++) begin
         kind_inc = (step.kind == whfm_pkg::KIND_CODES[k]);
         // eviction undoes the oldest entry's kind
         kind_dec = step.evict && (slot_entry.kind == whfm_pkg::KIND_CODES[k])
                    && (kind_cnt_ff[k] != '0);
         kind_cnt_in[k] = kind_cnt_ff[k] + CW'(kind_inc) - CW'(kind_dec);
      end

      if (step.failed && (total_ff != '1)) begin
         total_in = total_ff + whfm_pkg::TOTAL_W'(1);
      end else begin
         total_in = total_ff;
      end

      if (step.clear) begin
         win_cnt_in = '0;
         total_in   = '0;
         for (int k = 0; k < whfm_pkg::N_KINDS; k++) begin
            kind_cnt_in[k] = '0;
         end
      end

      win_cmp = CMPW'(win_cnt_in);
      if (win_cmp > CMPW'(thresh.emergency_above)) begin
         health_in = whfm_pkg::HEALTH_EMERGENCY;
      end else if (win_cmp > CMPW'(thresh.critical_above)) begin
         health_in = whfm_pkg::HEALTH_CRITICAL;
      end else if (win_cmp > CMPW'(thresh.warning_above)) begin
         health_in = whfm_pkg::HEALTH_WARNING;
      end else begin
         health_in = whfm_pkg::HEALTH_GOOD;
      end
   end

   // the output register holds until taken; a new item may load as it leaves
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cnt_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < whfm_pkg::N_KINDS; k++) begin
            kind_cnt_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            win_cnt_ff <= win_cnt_in;
            total_ff   <= total_in;
            for (int k = 0; k < whfm_pkg::N_KINDS; k++) begin
               kind_cnt_ff[k] <= kind_cnt_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         health_ff    <= health_in;
         held_ff      <= whfm_pkg::OUT_W'(fill);
         recent_ff    <= whfm_pkg::OUT_W'(win_cnt_in);
         total_out_ff <= total_in;
         for (int k = 0; k < whfm_pkg::N_KINDS; k++) begin
            kind_out_ff[k] <= whfm_pkg::OUT_W'(kind_cnt_in[k]);
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_health               = health_ff;
   assign rsp_held_samples         = held_ff;
   assign rsp_recent_failures      = recent_ff;
   assign rsp_failure_total        = total_out_ff;
   assign rsp_laser_in_history     = kind_out_ff[0];
   assign rsp_voltage_in_history   = kind_out_ff[1];
   assign rsp_em_in_history        = kind_out_ff[2];
   assign rsp_rowhammer_in_history = kind_out_ff[3];

   `WHFM_ASSERT_NOW(a_win_bound, clock, reset, 1'b1, win_cnt_ff <= CW'(WIN_LEN), "window count past window length")
   `WHFM_ASSERT_NEXT(a_clear_zero, clock, reset, fire && step.clear, (total_ff == '0) && (win_cnt_ff == '0), "counts not zero after clear")
   `WHFM_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(fire), "result shown with no item finished")

endmodule

>>> rtl/windowed_fault_health_monitor_core.sv
// Pipeline: the accept edge loads the step register and the ring read registers;
// the result register loads from them when no stalled result holds the count stage.
// Throughput: one item per cycle unless stalled; the ring memory gives both reads
// (evicted slot and window exit slot) and the write in the accept cycle. A stalled
// result holds the item behind it, and that holds the input in the same cycle.
// Reset (synchronous): pointers, counts and pipeline valids clear, thresholds
// return to 1, 5 and 10. Ring contents are not cleared; entries beyond the
// fill count are never consulted.
`include "windowed_fault_health_monitor_core_macros.svh"

module windowed_fault_health_monitor_core #(
   parameter int unsigned HISTORY_DEPTH = 1024,
   parameter int unsigned RECENT_WINDOW = 50
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic                                 req_check_passed,
   input  logic [whfm_pkg::KIND_W-1:0]          req_fault_kind,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_health,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_held_samples,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_recent_failures,
   output logic [whfm_pkg::TOTAL_W-1:0]         rsp_failure_total,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_laser_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_voltage_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_em_in_history,
   output logic [whfm_pkg::OUT_W-1:0]           rsp_rowhammer_in_history,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [whfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [whfm_pkg::THR_W-1:0]           csr_data
);

   localparam int unsigned WIN_LEN = (RECENT_WINDOW < HISTORY_DEPTH) ? RECENT_WINDOW
                                                                     : HISTORY_DEPTH;
   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

   logic                  accept;
   logic                  is_clear;
   logic                  full;
   logic                  s1_fire;
   logic [AW-1:0]         head_ff;
   logic [AW-1:0]         head_in;
   logic [CW-1:0]         fill_ff;
   logic [CW-1:0]         fill_in;
   logic [AW:0]           win_sum;
   logic [AW-1:0]         win_addr;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   whfm_pkg::step_type    step_in;
   whfm_pkg::step_type    s1_step_ff;
   logic [CW-1:0]         s1_fill_ff;
   whfm_pkg::entry_type   wr_entry;
   whfm_pkg::entry_type   slot_entry;
   whfm_pkg::entry_type   win_entry;
   whfm_pkg::thresh_type  thresh_ff;

   assign s1_fire   = s1_valid_ff & ~(rsp_valid & rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_fire;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign is_clear = (whfm_pkg::func_type'(req_func) == whfm_pkg::FUNC_CLEAR);
   assign full     = (fill_ff == CW'(HISTORY_DEPTH));

   // slot of the entry leaving the recent window, head - WIN_LEN modulo depth
   assign win_sum  = {1'b0, head_ff} + (AW+1)'(HISTORY_DEPTH - WIN_LEN);
   assign win_addr = (win_sum >= (AW+1)'(HISTORY_DEPTH))
                     ? AW'(win_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(win_sum);

   always_comb begin
      step_in.clear     = is_clear;
      step_in.failed    = ~req_check_passed & ~is_clear;
      step_in.kind      = is_clear ? '0 : req_fault_kind;
      step_in.win_leave = ~is_clear & (fill_ff >= CW'(WIN_LEN));
      step_in.evict     = ~is_clear & full;

      wr_entry.failed = ~req_check_passed;
      wr_entry.kind   = req_fault_kind;

      head_in = head_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (is_clear) begin
            head_in = '0;
            fill_in = '0;
         end else begin
            head_in = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            fill_in = full ? fill_ff : fill_ff + CW'(1);
         end
      end

      s1_valid_in = accept | (s1_valid_ff & ~s1_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff                   <= '0;
         fill_ff                   <= '0;
         s1_valid_ff               <= 1'b0;
         thresh_ff.warning_above   <= whfm_pkg::WARNING_RESET;
         thresh_ff.critical_above  <= whfm_pkg::CRITICAL_RESET;
         thresh_ff.emergency_above <= whfm_pkg::EMERGENCY_RESET;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               whfm_pkg::CSR_WARNING:   thresh_ff.warning_above   <= csr_data;
               whfm_pkg::CSR_CRITICAL:  thresh_ff.critical_above  <= csr_data;
               whfm_pkg::CSR_EMERGENCY: thresh_ff.emergency_above <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_step_ff <= step_in;
         s1_fill_ff <= fill_in;
      end
   end

   whfm_ring #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock     (clock),
      .rd_en     (accept),
      .wr_en     (accept & ~is_clear),
      .slot_addr (head_ff),
      .win_addr  (win_addr),
      .wr_data   (wr_entry),
      .slot_data (slot_entry),
      .win_data  (win_entry)
   );

   whfm_tally #(
      .CW      (CW),
      .WIN_LEN (WIN_LEN)
   ) u_tally (
      .clock                    (clock),
      .reset                    (reset),
      .fire                     (s1_fire),
      .step                     (s1_step_ff),
      .fill                     (s1_fill_ff),
      .slot_entry               (slot_entry),
      .win_entry                (win_entry),
      .thresh                   (thresh_ff),
      .rsp_stall                (rsp_stall),
      .rsp_valid                (rsp_valid),
      .rsp_health               (rsp_health),
      .rsp_held_samples         (rsp_held_samples),
      .rsp_recent_failures      (rsp_recent_failures),
      .rsp_failure_total        (rsp_failure_total),
      .rsp_laser_in_history     (rsp_laser_in_history),
      .rsp_voltage_in_history   (rsp_voltage_in_history),
      .rsp_em_in_history        (rsp_em_in_history),
      .rsp_rowhammer_in_history (rsp_rowhammer_in_history)
   );

   `WHFM_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(HISTORY_DEPTH), "fill count past ring depth")
   `WHFM_ASSERT_NOW(a_head_bound, clock, reset, 1'b1, head_ff <= AW'(HISTORY_DEPTH - 1), "ring head out of range")
   `WHFM_ASSERT_NEXT(a_fill_step, clock, reset, accept && !is_clear && !full, fill_ff == $past(fill_ff) + CW'(1), "fill count did not grow on record")

endmodule

>>> verif/windowed_fault_health_monitor_core_tb.sv
module windowed_fault_health_monitor_core_tb;

   localparam int unsigned HIST      = 1024;
   localparam int unsigned WIN       = 50;
   localparam int unsigned LONG_HOLD = 200;
   localparam time         RUN_LIMIT = 2_000_000;

   localparam logic [whfm_pkg::KIND_W-1:0]    KIND_NONE   = 3'd0;
   localparam logic [whfm_pkg::KIND_W-1:0]    KIND_SPARE5 = 3'd5;
   localparam logic [whfm_pkg::KIND_W-1:0]    KIND_SPARE6 = 3'd6;
   localparam logic [whfm_pkg::KIND_W-1:0]    KIND_SPARE7 = 3'd7;
   localparam logic [whfm_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam logic [whfm_pkg::THR_W-1:0]     THR_MAX     = 11'h7FF;

   typedef struct {
      whfm_pkg::health_type                health;
      logic [whfm_pkg::OUT_W-1:0]          held;
      logic [whfm_pkg::OUT_W-1:0]          recent;
      logic [whfm_pkg::TOTAL_W-1:0]        total;
      logic [whfm_pkg::OUT_W-1:0]          laser;
      logic [whfm_pkg::OUT_W-1:0]          voltage;
      logic [whfm_pkg::OUT_W-1:0]          em;
      logic [whfm_pkg::OUT_W-1:0]          rowhammer;
   } health_report_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_func;
   logic                                req_check_passed;
   logic [whfm_pkg::KIND_W-1:0]         req_fault_kind;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [1:0]                          rsp_health;
   logic [whfm_pkg::OUT_W-1:0]          rsp_held_samples;
   logic [whfm_pkg::OUT_W-1:0]          rsp_recent_failures;
   logic [whfm_pkg::TOTAL_W-1:0]        rsp_failure_total;
   logic [whfm_pkg::OUT_W-1:0]          rsp_laser_in_history;
   logic [whfm_pkg::OUT_W-1:0]          rsp_voltage_in_history;
   logic [whfm_pkg::OUT_W-1:0]          rsp_em_in_history;
   logic [whfm_pkg::OUT_W-1:0]          rsp_rowhammer_in_history;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [whfm_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [whfm_pkg::THR_W-1:0]          csr_data;

   // predictor state
   logic [3:0]                          outcome_mem [HIST];
   int unsigned                         wr_slot;
   int unsigned                         held_count;
   int unsigned                         window_fails;
   logic [whfm_pkg::TOTAL_W-1:0]        fails_since_clear;
   int unsigned                         kind_tally [whfm_pkg::N_KINDS];
   logic [whfm_pkg::THR_W-1:0]          th_warning;
   logic [whfm_pkg::THR_W-1:0]          th_critical;
   logic [whfm_pkg::THR_W-1:0]          th_emergency;

   health_report_type                   pending_reports [$];
   int unsigned                         mismatch_count;

   // receiver stall control
   int unsigned           stall_max;
   int unsigned           stall_density;
   int unsigned           hold_requests;
   int unsigned           holds_served;
   int unsigned           hold_left;
   int unsigned           stall_cyc;

   windowed_fault_health_monitor_core #(
      .HISTORY_DEPTH(HIST),
      .RECENT_WINDOW(WIN)
   ) u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_func                 (req_func),
      .req_check_passed         (req_check_passed),
      .req_fault_kind           (req_fault_kind),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_health               (rsp_health),
      .rsp_held_samples         (rsp_held_samples),
      .rsp_recent_failures      (rsp_recent_failures),
      .rsp_failure_total        (rsp_failure_total),
      .rsp_laser_in_history     (rsp_laser_in_history),
      .rsp_voltage_in_history   (rsp_voltage_in_history),
      .rsp_em_in_history        (rsp_em_in_history),
      .rsp_rowhammer_in_history (rsp_rowhammer_in_history),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [whfm_pkg::TOTAL_W-1:0] got,
                              input logic [whfm_pkg::TOTAL_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic bit is_counted_kind(input logic [whfm_pkg::KIND_W-1:0] kind);
      return kind >= whfm_pkg::KIND_LASER && kind <= whfm_pkg::KIND_ROWHAMMER;
   endfunction

   // advance the monitor state by one item and queue the report it gives
   task automatic predict_health(input whfm_pkg::func_type f, input logic passed,
                                 input logic [whfm_pkg::KIND_W-1:0] kind);
      health_report_type r;
      int unsigned       exit_slot;
      logic [3:0]        old;
      if (f == whfm_pkg::FUNC_CLEAR) begin
         wr_slot = 0;
         held_count = 0;
         window_fails = 0;
         fails_since_clear = '0;
         foreach (kind_tally[k]) kind_tally[k] = 0;
      end else begin
         if (held_count >= WIN) begin
            exit_slot = (wr_slot + HIST - WIN) % HIST;
            if (outcome_mem[exit_slot][3] && window_fails > 0) window_fails--;
         end
         if (held_count >= HIST) begin
            old = outcome_mem[wr_slot];
            if (is_counted_kind(old[2:0])
                && kind_tally[int'(old[2:0] - whfm_pkg::KIND_LASER)] > 0)
               kind_tally[int'(old[2:0] - whfm_pkg::KIND_LASER)]--;
         end else begin
            held_count++;
         end
         outcome_mem[wr_slot] = {~passed, kind};
         wr_slot = (wr_slot + 1) % HIST;
         if (is_counted_kind(kind)) kind_tally[int'(kind - whfm_pkg::KIND_LASER)]++;
         if (!passed) begin
            window_fails++;
            if (fails_since_clear != '1) fails_since_clear++;
         end
      end
      if (window_fails > th_emergency)
         r.health = whfm_pkg::HEALTH_EMERGENCY;
      else if (window_fails > th_critical)
         r.health = whfm_pkg::HEALTH_CRITICAL;
      else if (window_fails > th_warning)
         r.health = whfm_pkg::HEALTH_WARNING;
      else
         r.health = whfm_pkg::HEALTH_GOOD;
      r.held      = whfm_pkg::OUT_W'(held_count);
      r.recent    = whfm_pkg::OUT_W'(window_fails);
      r.total     = fails_since_clear;
      r.laser     = whfm_pkg::OUT_W'(kind_tally[0]);
      r.voltage   = whfm_pkg::OUT_W'(kind_tally[1]);
      r.em        = whfm_pkg::OUT_W'(kind_tally[2]);
      r.rowhammer = whfm_pkg::OUT_W'(kind_tally[3]);
      pending_reports = {pending_reports, r};
   endtask

   task automatic send_item(input whfm_pkg::func_type f, input logic passed,
                            input logic [whfm_pkg::KIND_W-1:0] kind);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_func         <= f;
      req_check_passed <= passed;
      req_fault_kind   <= kind;
      do @(posedge clock); while (req_stall);
      predict_health(f, passed, kind);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // stop sending and wait for every outstanding report, plus pipeline slack
   task automatic drain_reports;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [whfm_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [whfm_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         whfm_pkg::CSR_WARNING:   th_warning = value;
         whfm_pkg::CSR_CRITICAL:  th_critical = value;
         whfm_pkg::CSR_EMERGENCY: th_emergency = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(input logic [whfm_pkg::THR_W-1:0] warn,
                                 input logic [whfm_pkg::THR_W-1:0] crit,
                                 input logic [whfm_pkg::THR_W-1:0] emerg);
      drain_reports();
      write_register(whfm_pkg::CSR_WARNING, warn);
      write_register(whfm_pkg::CSR_CRITICAL, crit);
      write_register(whfm_pkg::CSR_EMERGENCY, emerg);
   endtask

   // bursts share a failure rate so the window count swings across the levels
   task automatic run_outcomes(input int unsigned n_items, input int unsigned clear_pct,
                               input bit gaps_on);
      int unsigned        sent;
      int unsigned        burst;
      int unsigned        fail_pct;
      whfm_pkg::func_type f;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(24, 1);
         fail_pct = $urandom_range(100);
         repeat (burst) begin
            if (sent < n_items) begin
               f = ($urandom_range(99) < clear_pct) ? whfm_pkg::FUNC_CLEAR
                                                    : whfm_pkg::FUNC_RECORD;
               send_item(f, $urandom_range(99) >= fail_pct,
                         whfm_pkg::KIND_W'($urandom_range(7)));
               sent++;
            end
         end
         if (gaps_on && $urandom_range(2) != 0) idle_gap($urandom_range(10, 1));
      end
   endtask

   task automatic test_reset_thresholds;
      send_item(whfm_pkg::FUNC_RECORD, 1'b1, KIND_NONE);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_LASER);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_VOLTAGE);
      send_item(whfm_pkg::FUNC_CLEAR, 1'b0, KIND_SPARE7);
   endtask

   task automatic test_health_levels;
      set_thresholds(11'd0, 11'd1, 11'd2);
      write_register(CSR_SPARE, THR_MAX);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_EM);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_ROWHAMMER);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, KIND_SPARE5);
      send_item(whfm_pkg::FUNC_RECORD, 1'b1, KIND_SPARE6);
      send_item(whfm_pkg::FUNC_RECORD, 1'b1, KIND_SPARE7);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, KIND_NONE);
      send_item(whfm_pkg::FUNC_CLEAR, 1'b1, whfm_pkg::KIND_ROWHAMMER);
      set_thresholds(THR_MAX, THR_MAX, THR_MAX);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_LASER);
      send_item(whfm_pkg::FUNC_RECORD, 1'b1, whfm_pkg::KIND_VOLTAGE);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_VOLTAGE);
      // equal to threshold stays good, one more is emergency
      set_thresholds(11'd3, 11'd3, 11'd3);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_EM);
      send_item(whfm_pkg::FUNC_RECORD, 1'b0, whfm_pkg::KIND_ROWHAMMER);
   endtask

   task automatic test_random_mix;
      set_thresholds(11'd3, 11'd8, 11'd15);
      stall_max = 60;
      run_outcomes(100, 3, 1'b1);
   endtask

   // long run with no clear after the first so the ring wraps and evicts
   task automatic test_fill_and_evict;
      set_thresholds(11'd20, 11'd30, 11'd45);
      send_item(whfm_pkg::FUNC_CLEAR, 1'b1, KIND_NONE);
      stall_max = 40;
      run_outcomes(1150, 0, 1'b1);
   endtask

   task automatic test_output_hold_off;
      drain_reports();
      stall_max = 0;
      hold_requests++;
      run_outcomes(40, 2, 1'b0);
      drain_reports();
   endtask

   task automatic test_threshold_corners;
      stall_max = 80;
      set_thresholds(11'd40, 11'd10, 11'd0);
      run_outcomes(60, 2, 1'b1);
      set_thresholds(THR_MAX, 11'd0, 11'd1024);
      run_outcomes(60, 2, 1'b1);
      set_thresholds(11'd1024, 11'd1024, 11'd1024);
      run_outcomes(40, 2, 1'b1);
      set_thresholds(11'd47, 11'd48, 11'd49);
      run_outcomes(40, 0, 1'b1);
   endtask

   // receiver: random stall density, long hold-off on request
   always @(negedge clock) begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 128 == 0) stall_density <= $urandom_range(stall_max);
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= LONG_HOLD;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_density);
      end
   end

   always @(posedge clock) begin
      health_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("report with no item outstanding");
         end else begin
            want = pending_reports.pop_front();
            check_field("health", rsp_health, want.health);
            check_field("held_samples", rsp_held_samples, want.held);
            check_field("recent_failures", rsp_recent_failures, want.recent);
            check_field("failure_total", rsp_failure_total, want.total);
            check_field("laser_in_history", rsp_laser_in_history, want.laser);
            check_field("voltage_in_history", rsp_voltage_in_history, want.voltage);
            check_field("em_in_history", rsp_em_in_history, want.em);
            check_field("rowhammer_in_history", rsp_rowhammer_in_history, want.rowhammer);
         end
      end
   end

   initial begin
      #RUN_LIMIT;
      $display("timeout, %0d reports outstanding", pending_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = 1'b0;
      req_check_passed = 1'b0;
      req_fault_kind   = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      stall_max        = 0;
      stall_density    = 0;
      hold_requests    = 0;
      holds_served     = 0;
      hold_left        = 0;
      stall_cyc        = 0;
      mismatch_count   = 0;
      wr_slot          = 0;
      held_count       = 0;
      window_fails     = 0;
      fails_since_clear = '0;
      foreach (kind_tally[k]) kind_tally[k] = 0;
      th_warning       = whfm_pkg::WARNING_RESET;
      th_critical      = whfm_pkg::CRITICAL_RESET;
      th_emergency     = whfm_pkg::EMERGENCY_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_thresholds();
      test_health_levels();
      test_random_mix();
      test_fill_and_evict();
      test_output_hold_off();
      test_threshold_corners();

      stall_max = 0;
      drain_reports();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/whfm_pkg.sv
rtl/whfm_ring.sv
rtl/whfm_tally.sv
rtl/windowed_fault_health_monitor_core.sv
verif/windowed_fault_health_monitor_core_tb.sv
